// File: design/rpc_pkg.sv
// Shared widths, constants, the arctangent table and angle case codes for the
// relative position polar converter. Depends on nothing; every file but rpc_delay.sv uses it.
package rpc_pkg;

	// Result field widths.
	localparam int FIRST_W  = 22;
	localparam int SECOND_W = 21;
	localparam int THIRD_W  = 21;

	// Values of the mode register.
	localparam logic MODE_CART  = 1'b0;
	localparam logic MODE_POLAR = 1'b1;

	// A component magnitude is clamped at 2^21. Any magnitude that large already
	// drives the planar distance into saturation.
	localparam int MAG_W = 22;
	localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(1) << (MAG_W - 1);

	// The root is taken of the low 42 bits of the square sum, one result bit per stage.
	localparam int SQ_W       = 2 * (MAG_W - 1);
	localparam int ROOT_STEPS = SQ_W / 2;
	localparam logic [FIRST_W-1:0] DIST_MAX = {1'b0, {(FIRST_W - 1){1'b1}}};

	// The CORDIC inputs are scaled so that full scale sits at 2^40, and the
	// angle accumulator counts in units where 2^31 is pi.
	localparam int SCALE_REF    = 40;
	localparam int XY_W         = SCALE_REF + 3;
	localparam int ANGLE_UNIT_W = 32;
	localparam int Z_W          = ANGLE_UNIT_W + 2;
	localparam logic signed [Z_W-1:0] Z_PI = Z_W'(1) <<< (ANGLE_UNIT_W - 1);

	localparam int CORDIC_STEPS = 31;
	localparam logic [ANGLE_UNIT_W-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
		32'd1
	};

	// How the angle of an item is found.
	typedef logic [2:0] ang_case_t;
	localparam ang_case_t ANG_CORDIC   = 3'd0;
	localparam ang_case_t ANG_ZERO     = 3'd1;
	localparam ang_case_t ANG_PI       = 3'd2;
	localparam ang_case_t ANG_POS_HALF = 3'd3;
	localparam ang_case_t ANG_NEG_HALF = 3'd4;

	// Stage counts of the parts of the pipeline.
	localparam int FRONT_LAT  = 2;
	localparam int CORDIC_LAT = CORDIC_STEPS + 1;
	localparam int SQRT_LAT   = 2 + ROOT_STEPS + 1;
	localparam int PIPE_LAT   = FRONT_LAT + CORDIC_LAT;

endpackage

// File: design/rpc_if.sv
// Beacon and result channel interfaces of the relative position polar converter.
// Depends on rpc_pkg for the result field widths.
interface rpc_beacon_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] own_x;
	logic signed [COORD_BITS-1:0] own_y;
	logic signed [COORD_BITS-1:0] own_z;
	logic signed [COORD_BITS-1:0] target_x;
	logic signed [COORD_BITS-1:0] target_y;
	logic signed [COORD_BITS-1:0] target_z;
	logic                         is_self;

	modport source (
		output valid, own_x, own_y, own_z, target_x, target_y, target_z, is_self,
		input  ready
	);
	modport sink (
		input  valid, own_x, own_y, own_z, target_x, target_y, target_z, is_self,
		output ready
	);
endinterface

interface rpc_result_if;
	import rpc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [FIRST_W-1:0]  first_value;
	logic signed [SECOND_W-1:0] second_value;
	logic signed [THIRD_W-1:0]  third_value;

	modport source (
		output valid, first_value, second_value, third_value,
		input  ready
	);
	modport sink (
		input  valid, first_value, second_value, third_value,
		output ready
	);
endinterface

// File: design/rpc_front.sv
// Front end: differences of the positions, clamped magnitudes, cartesian result
// fields and the CORDIC start vector. Two register stages. Depends on rpc_pkg.
module rpc_front #(
	parameter int COORD_BITS = 20
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [COORD_BITS-1:0]        own_x,
	input  logic signed [COORD_BITS-1:0]        own_y,
	input  logic signed [COORD_BITS-1:0]        own_z,
	input  logic signed [COORD_BITS-1:0]        target_x,
	input  logic signed [COORD_BITS-1:0]        target_y,
	input  logic signed [COORD_BITS-1:0]        target_z,
	output logic [rpc_pkg::FIRST_W-1:0]         cart_first,
	output logic [rpc_pkg::SECOND_W-1:0]        cart_second,
	output logic [rpc_pkg::THIRD_W-1:0]         cart_third,
	output logic [rpc_pkg::MAG_W-1:0]           mag_x,
	output logic [rpc_pkg::MAG_W-1:0]           mag_z,
	output logic signed [rpc_pkg::XY_W-1:0]     cordic_x,
	output logic signed [rpc_pkg::XY_W-1:0]     cordic_y,
	output logic signed [rpc_pkg::Z_W-1:0]      cordic_z,
	output rpc_pkg::ang_case_t                  ang_case
);
	import rpc_pkg::*;

	localparam int DW       = COORD_BITS + 1;
	localparam int EXT_W    = DW + FIRST_W;
	localparam int MAGW     = (DW + 1 > MAG_W + 1) ? DW + 1 : MAG_W + 1;
	localparam int SCALE_SH = SCALE_REF - COORD_BITS;

	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;

	logic signed [DW:0]      dxw, dzw;
	logic [DW:0]             ax, az;
	logic [MAGW-1:0]         axw, azw;
	logic [MAG_W-1:0]        mx, mz;
	logic signed [EXT_W-1:0] ex, ey, ez;
	logic signed [XY_W-1:0]  sx, sz, cx, cy;
	logic signed [Z_W-1:0]   cz;
	ang_case_t               ac;

	logic [FIRST_W-1:0]     cart_first_s2;
	logic [SECOND_W-1:0]    cart_second_s2;
	logic [THIRD_W-1:0]     cart_third_s2;
	logic [MAG_W-1:0]       mag_x_s2, mag_z_s2;
	logic signed [XY_W-1:0] cordic_x_s2, cordic_y_s2;
	logic signed [Z_W-1:0]  cordic_z_s2;
	ang_case_t              ang_case_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(target_x) - DW'(own_x);
			dy_s1 <= DW'(target_y) - DW'(own_y);
			dz_s1 <= DW'(target_z) - DW'(own_z);
		end
	end

	always_comb begin
		dxw = (DW + 1)'(dx_s1);
		dzw = (DW + 1)'(dz_s1);
		ax  = dxw[DW] ? unsigned'(-dxw) : unsigned'(dxw);
		az  = dzw[DW] ? unsigned'(-dzw) : unsigned'(dzw);
		axw = MAGW'(ax);
		azw = MAGW'(az);
		mx  = (axw > MAGW'(MAG_CLAMP)) ? MAG_CLAMP : axw[MAG_W-1:0];
		mz  = (azw > MAGW'(MAG_CLAMP)) ? MAG_CLAMP : azw[MAG_W-1:0];

		// Cartesian fields keep the low bits of the sign-extended difference.
		ex = EXT_W'(dx_s1);
		ey = EXT_W'(dy_s1);
		ez = EXT_W'(dz_s1);

		// A vector in the left half plane is turned by pi first, so that the
		// iterations only ever see a non-negative x.
		sx = XY_W'(dx_s1) <<< SCALE_SH;
		sz = XY_W'(dz_s1) <<< SCALE_SH;
		if (dx_s1[DW-1]) begin
			cx = -sx;
			cy = -sz;
			cz = dz_s1[DW-1] ? -Z_PI : Z_PI;
		end else begin
			cx = sx;
			cy = sz;
			cz = '0;
		end

		if (dz_s1 == '0) begin
			ac = dx_s1[DW-1] ? ANG_PI : ANG_ZERO;
		end else if (dx_s1 == '0) begin
			ac = dz_s1[DW-1] ? ANG_NEG_HALF : ANG_POS_HALF;
		end else begin
			ac = ANG_CORDIC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cart_first_s2  <= ex[FIRST_W-1:0];
			cart_second_s2 <= ey[SECOND_W-1:0];
			cart_third_s2  <= ez[THIRD_W-1:0];
			mag_x_s2       <= mx;
			mag_z_s2       <= mz;
			cordic_x_s2    <= cx;
			cordic_y_s2    <= cy;
			cordic_z_s2    <= cz;
			ang_case_s2    <= ac;
		end
	end

	assign cart_first  = cart_first_s2;
	assign cart_second = cart_second_s2;
	assign cart_third  = cart_third_s2;
	assign mag_x       = mag_x_s2;
	assign mag_z       = mag_z_s2;
	assign cordic_x    = cordic_x_s2;
	assign cordic_y    = cordic_y_s2;
	assign cordic_z    = cordic_z_s2;
	assign ang_case    = ang_case_s2;

endmodule

// File: design/rpc_isqrt.sv
// Planar distance: squares, sum, a pipelined bit-per-stage square root, then
// rounding to nearest and saturation. Depends on rpc_pkg.
module rpc_isqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rpc_pkg::MAG_W-1:0]    mag_a,
	input  logic [rpc_pkg::MAG_W-1:0]    mag_b,
	output logic [rpc_pkg::FIRST_W-1:0]  distance
);
	import rpc_pkg::*;

	localparam int PROD_W = 2 * MAG_W;

	logic [PROD_W-1:0] sq_a_s1, sq_b_s1;
	logic [PROD_W:0]   sum;
	logic [SQ_W-1:0]   rem_s2;
	logic              big_s2;

	logic [SQ_W-1:0] rem_s  [ROOT_STEPS];
	logic [SQ_W-1:0] root_s [ROOT_STEPS];
	logic            big_s  [ROOT_STEPS];

	logic [FIRST_W-1:0] root_lo, rounded;
	logic               round_up;
	logic [FIRST_W-1:0] dist_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_a_s1 <= mag_a * mag_a;
			sq_b_s1 <= mag_b * mag_b;
		end
	end

	// A sum of 2^42 or more has a root beyond the largest distance.
	assign sum = (PROD_W + 1)'(sq_a_s1) + (PROD_W + 1)'(sq_b_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= sum[SQ_W-1:0];
			big_s2 <= |sum[PROD_W:SQ_W];
		end
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0] rem_p, root_p, trial;
		logic            big_p;

		if (k == 0) begin : g_first
			assign rem_p  = rem_s2;
			assign root_p = '0;
			assign big_p  = big_s2;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign big_p  = big_s[k-1];
		end

		assign trial = root_p + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_p >= trial) begin
					rem_s[k]  <= rem_p - trial;
					root_s[k] <= (root_p >> 1) + BIT;
				end else begin
					rem_s[k]  <= rem_p;
					root_s[k] <= root_p >> 1;
				end
				big_s[k] <= big_p;
			end
		end
	end

	// The remainder left over is the sum less the square of the root, so the
	// root rounds up when it exceeds the root itself.
	always_comb begin
		root_lo  = root_s[ROOT_STEPS-1][FIRST_W-1:0];
		round_up = rem_s[ROOT_STEPS-1] > root_s[ROOT_STEPS-1];
		rounded  = root_lo + FIRST_W'(round_up);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (big_s[ROOT_STEPS-1] || rounded[FIRST_W-1]) begin
				dist_s24 <= DIST_MAX;
			end else begin
				dist_s24 <= rounded;
			end
		end
	end

	assign distance = dist_s24;

endmodule

// File: design/rpc_cordic.sv
// Angle: a fully unrolled vectoring CORDIC of 31 stages, then rounding to the
// binary angle and the exact cases on the axes. Depends on rpc_pkg.
module rpc_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rpc_pkg::XY_W-1:0]   x_in,
	input  logic signed [rpc_pkg::XY_W-1:0]   y_in,
	input  logic signed [rpc_pkg::Z_W-1:0]    z_in,
	input  rpc_pkg::ang_case_t                case_in,
	output logic signed [ANGLE_BITS:0]        angle
);
	import rpc_pkg::*;

	localparam int SH = ANGLE_UNIT_W - ANGLE_BITS;
	localparam int AW = ANGLE_BITS + 1;
	localparam int RW = Z_W + 1;
	localparam logic signed [RW-1:0] RND    = RW'(1) <<< (SH - 1);
	localparam logic signed [RW-1:0] HALF_R = RW'(1) <<< (ANGLE_BITS - 1);
	localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (ANGLE_BITS - 1);
	localparam logic signed [AW-1:0] QTR_A  = AW'(1) <<< (ANGLE_BITS - 2);

	logic signed [XY_W-1:0] x_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS];
	logic signed [Z_W-1:0]  z_s [CORDIC_STEPS];
	ang_case_t              c_s [CORDIC_STEPS];

	logic signed [RW-1:0] zr, rr;
	logic signed [AW-1:0] ang_cordic;
	logic signed [AW-1:0] angle_s32;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XY_W-1:0] xp, yp, xs, ys;
		logic signed [Z_W-1:0]  zp;
		ang_case_t              cp;

		if (i == 0) begin : g_first
			assign xp = x_in;
			assign yp = y_in;
			assign zp = z_in;
			assign cp = case_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign cp = c_s[i-1];
		end

		assign xs = xp >>> i;
		assign ys = yp >>> i;

		// Rotate toward the x axis; the sign of y picks the direction.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yp[XY_W-1]) begin
					x_s[i] <= xp + ys;
					y_s[i] <= yp - xs;
					z_s[i] <= zp + Z_W'(ATAN_UNITS[i]);
				end else begin
					x_s[i] <= xp - ys;
					y_s[i] <= yp + xs;
					z_s[i] <= zp - Z_W'(ATAN_UNITS[i]);
				end
				c_s[i] <= cp;
			end
		end
	end

	// Round half up, then fold anything at or below -pi, or above pi, onto pi.
	always_comb begin
		zr = RW'(z_s[CORDIC_STEPS-1]) + RND;
		rr = zr >>> SH;
		if (rr <= -HALF_R || rr > HALF_R) begin
			ang_cordic = HALF_A;
		end else begin
			ang_cordic = rr[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (c_s[CORDIC_STEPS-1])
				ANG_CORDIC:   angle_s32 <= ang_cordic;
				ANG_ZERO:     angle_s32 <= '0;
				ANG_PI:       angle_s32 <= HALF_A;
				ANG_POS_HALF: angle_s32 <= QTR_A;
				ANG_NEG_HALF: angle_s32 <= -QTR_A;
				default:      angle_s32 <= '0;
			endcase
		end
	end

	assign angle = angle_s32;

endmodule

// File: design/rpc_delay.sv
// Enabled shift line that keeps a value in step with a longer parallel path.
// Depends on nothing.
module rpc_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

// File: design/relative_position_polar_converter.sv
// Relative position polar converter. Each beat on the beacon channel carries the
// sensor's own position and one beacon's position; the block subtracts them and
// returns either the differences dx, dy, dz (mode 0) or the planar distance
// sqrt(dx^2 + dz^2), a zero and the angle atan2(dz, dx) as a binary angle where
// 2^(ANGLE_BITS-1) is pi (mode 1). A beat flagged is_self is taken and gives no
// result. The block accepts one beat in every cycle while its output is not stalled.
// A beat passes through the two front stages, the 31 unrolled CORDIC iterations,
// one rounding stage and the output register; the 21-stage square root runs
// beside them and is delayed to match. The whole pipeline moves as one: while a
// result waits at the output unread, nothing advances and the beacon channel
// holds ready low. Mode is written through cfg_we and cfg_wdata; the user must
// write it only while no beat is in flight, which the block does not enforce.
// Depends on rpc_pkg, the channel interfaces and the rpc_* submodules.
module relative_position_polar_converter #(
	parameter int COORD_BITS = 20,
	parameter int ANGLE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	rpc_beacon_if.sink   beacon,
	rpc_result_if.source result
);
	import rpc_pkg::*;

	localparam int AW     = ANGLE_BITS + 1;
	localparam int CART_W = FIRST_W + SECOND_W + THIRD_W;
	localparam int ANG_EXT_W = AW + THIRD_W;

	// Global advance: every stage moves when the output register is empty or
	// its beat is being taken.
	logic en;

	logic mode_q;
	logic [PIPE_LAT-1:0] valid_line_q;

	logic [FIRST_W-1:0]     cart_first;
	logic [SECOND_W-1:0]    cart_second;
	logic [THIRD_W-1:0]     cart_third;
	logic [MAG_W-1:0]       mag_x, mag_z;
	logic signed [XY_W-1:0] cordic_x, cordic_y;
	logic signed [Z_W-1:0]  cordic_z;
	ang_case_t              ang_case;

	logic [FIRST_W-1:0]   distance, dist_d;
	logic signed [AW-1:0] angle;
	logic signed [ANG_EXT_W-1:0] angle_ext;
	logic [CART_W-1:0]    cart_d;

	logic                       out_valid_s35;
	logic signed [FIRST_W-1:0]  first_s35;
	logic signed [SECOND_W-1:0] second_s35;
	logic signed [THIRD_W-1:0]  third_s35;

	assign en           = !out_valid_s35 || result.ready;
	assign beacon.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CART;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Valid bits run beside the data; a self beat enters as a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_line_q <= '0;
		end else if (en) begin
			valid_line_q <= {valid_line_q[PIPE_LAT-2:0], beacon.valid && !beacon.is_self};
		end
	end

	rpc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.en          (en),
		.own_x       (beacon.own_x),
		.own_y       (beacon.own_y),
		.own_z       (beacon.own_z),
		.target_x    (beacon.target_x),
		.target_y    (beacon.target_y),
		.target_z    (beacon.target_z),
		.cart_first  (cart_first),
		.cart_second (cart_second),
		.cart_third  (cart_third),
		.mag_x       (mag_x),
		.mag_z       (mag_z),
		.cordic_x    (cordic_x),
		.cordic_y    (cordic_y),
		.cordic_z    (cordic_z),
		.ang_case    (ang_case)
	);

	rpc_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.mag_a    (mag_x),
		.mag_b    (mag_z),
		.distance (distance)
	);

	rpc_cordic #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_cordic (
		.clk     (clk),
		.en      (en),
		.x_in    (cordic_x),
		.y_in    (cordic_y),
		.z_in    (cordic_z),
		.case_in (ang_case),
		.angle   (angle)
	);

	// The distance finishes ahead of the angle and waits here for it.
	rpc_delay #(
		.WIDTH (FIRST_W),
		.DEPTH (CORDIC_LAT - SQRT_LAT)
	) u_dist_delay (
		.clk  (clk),
		.en   (en),
		.din  (distance),
		.dout (dist_d)
	);

	// The cartesian fields are ready after the front end and ride along.
	rpc_delay #(
		.WIDTH (CART_W),
		.DEPTH (CORDIC_LAT)
	) u_cart_delay (
		.clk  (clk),
		.en   (en),
		.din  ({cart_first, cart_second, cart_third}),
		.dout (cart_d)
	);

	// The angle field keeps the low bits of the sign-extended binary angle.
	assign angle_ext = ANG_EXT_W'(angle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s35 <= 1'b0;
		end else if (en) begin
			out_valid_s35 <= valid_line_q[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mode_q == MODE_POLAR) begin
				first_s35  <= dist_d;
				second_s35 <= '0;
				third_s35  <= angle_ext[THIRD_W-1:0];
			end else begin
				first_s35  <= cart_d[CART_W-1 -: FIRST_W];
				second_s35 <= cart_d[THIRD_W +: SECOND_W];
				third_s35  <= cart_d[THIRD_W-1:0];
			end
		end
	end

	assign result.valid        = out_valid_s35;
	assign result.first_value  = first_s35;
	assign result.second_value = second_s35;
	assign result.third_value  = third_s35;

	// A self beat must never put a valid bit into the pipeline.
	a_self_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		beacon.valid && beacon.ready && beacon.is_self |=> !valid_line_q[0])
		else $error("self beat entered the pipeline");

	// While the output is stalled the valid line must not move.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_line_q))
		else $error("valid line moved during a stall");

	// In polar mode the middle field is zero.
	a_polar_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && mode_q == MODE_POLAR |-> result.second_value == '0)
		else $error("polar result has a nonzero second field");

	// The planar distance is never negative.
	a_polar_dist_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && mode_q == MODE_POLAR |-> !result.first_value[FIRST_W-1])
		else $error("polar distance is negative");

endmodule

// File: tb/sv/tb_relative_position_polar_converter.sv
`timescale 1ns / 1ps
// Self-checking testbench for relative_position_polar_converter: directed and random beacon
// beats in both modes, checked against a predictor of its own. Depends on rpc_pkg, rpc_if.sv
// and the converter RTL.
module tb_relative_position_polar_converter;
	import rpc_pkg::*;

	localparam int COORD_BITS = 20;
	localparam int ANGLE_BITS = 16;

	// Largest coordinate magnitude that a beat may carry.
	localparam int CMAX = 524287;

	// Drain wait: longer than the pipeline depth PIPE_LAT, to give margin before a mode write
	// and at the end of the run.
	localparam int DRAIN_CYCLES = PIPE_LAT + 12;

	// Far above the slowest correct run: about 770 beats, each of which may meet a long gap
	// on both sides, plus the drains around each mode change and the long hold-off.
	localparam int unsigned CYCLE_LIMIT = 500000;

	// Angle arithmetic of the predictor: the CORDIC works in units where 2^31 is pi and
	// the differences are scaled so that full scale sits at 2^40.
	localparam longint PI_UNITS     = 64'sd2147483648;
	localparam longint COORD_SCALE  = 64'sd1 <<< (40 - COORD_BITS);
	localparam int     ANGLE_SHIFT  = 32 - ANGLE_BITS;
	localparam longint ANGLE_ROUND  = 64'sd1 <<< (ANGLE_SHIFT - 1);
	localparam longint HALF_TURN    = 64'sd1 <<< (ANGLE_BITS - 1);

	localparam longint BEARING_ATAN [31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1
	};

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t own_x;
		coord_t own_y;
		coord_t own_z;
		coord_t target_x;
		coord_t target_y;
		coord_t target_z;
		logic   is_self;
	} beacon_t;

	typedef struct {
		logic signed [FIRST_W-1:0]  first_value;
		logic signed [SECOND_W-1:0] second_value;
		logic signed [THIRD_W-1:0]  third_value;
	} fix_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	rpc_beacon_if #(.COORD_BITS(COORD_BITS)) beacon_bus ();
	rpc_result_if result_bus ();

	relative_position_polar_converter #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.beacon   (beacon_bus),
		.result   (result_bus)
	);

	// Shadow of the mode register, changed only together with a write to the block.
	logic conv_mode = MODE_CART;

	// Fixes still owed by the block, oldest first.
	fix_t pending_fixes[$];

	int          mismatches      = 0;
	int unsigned cycle_count     = 0;
	bit          send_idle_on    = 1'b1;
	bit          recv_idle_on    = 1'b1;
	int          hold_off_cycles = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// The whole run is bounded; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_relative_position_polar_converter: errors");
			$finish;
		end
	end

	// Idle stretches: mostly none or short, now and then a long one.
	function automatic int pick_idle(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Expected fix for one beat under the current mode. Cartesian mode returns the plain
	// differences. Polar mode returns the rounded planar range, a zero and the bearing
	// atan2(dz, dx) as a binary angle.
	function automatic fix_t predict_fix(input beacon_t b);
		longint          dx, dy, dz, x, y, acc, xs, ys, ang;
		longint unsigned ax, az, sum, rem, root, probe;
		fix_t            f;
		dx = longint'(b.target_x) - longint'(b.own_x);
		dy = longint'(b.target_y) - longint'(b.own_y);
		dz = longint'(b.target_z) - longint'(b.own_z);
		if (conv_mode == MODE_CART) begin
			f.first_value  = FIRST_W'(dx);
			f.second_value = SECOND_W'(dy);
			f.third_value  = THIRD_W'(dz);
			return f;
		end

		// Integer square root, one result bit per step, then rounded to nearest.
		ax = (dx < 0) ? -dx : dx;
		az = (dz < 0) ? -dz : dz;
		sum = ax * ax + az * az;
		rem = sum;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > sum)
			probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		if (sum - root * root > root)
			root++;
		if (root > longint'(DIST_MAX))
			root = longint'(DIST_MAX);
		f.first_value  = FIRST_W'(root);
		f.second_value = '0;

		// The axis directions are exact; both differences zero counts as angle zero, and a
		// negative dx on the axis gives pi rather than minus pi.
		if (dz == 0) begin
			ang = (dx < 0) ? HALF_TURN : 0;
		end else if (dx == 0) begin
			ang = (dz > 0) ? HALF_TURN / 2 : -(HALF_TURN / 2);
		end else begin
			// The left half plane is first turned by pi toward the side of dz.
			if (dx < 0) begin
				x = -dx * COORD_SCALE;
				y = -dz * COORD_SCALE;
				acc = (dz > 0) ? PI_UNITS : -PI_UNITS;
			end else begin
				x = dx * COORD_SCALE;
				y = dz * COORD_SCALE;
				acc = 0;
			end
			for (int i = 0; i < 31; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys;
					y -= xs;
					acc += BEARING_ATAN[i];
				end else begin
					x -= ys;
					y += xs;
					acc -= BEARING_ATAN[i];
				end
			end
			// Round half up, then fold anything outside (-pi, pi] onto pi.
			ang = (acc + ANGLE_ROUND) >>> ANGLE_SHIFT;
			if (ang <= -HALF_TURN || ang > HALF_TURN)
				ang = HALF_TURN;
		end
		f.third_value = THIRD_W'(ang);
		return f;
	endfunction

	function automatic beacon_t make_beacon(input int ox, input int oy, input int oz,
			input int tx, input int ty, input int tz, input logic self_flag);
		beacon_t b;
		b.own_x    = coord_t'(ox);
		b.own_y    = coord_t'(oy);
		b.own_z    = coord_t'(oz);
		b.target_x = coord_t'(tx);
		b.target_y = coord_t'(ty);
		b.target_z = coord_t'(tz);
		b.is_self  = self_flag;
		return b;
	endfunction

	function automatic coord_t rand_coord();
		return coord_t'(int'($urandom_range(0, 2 * CMAX)) - CMAX);
	endfunction

	function automatic coord_t rand_extreme();
		return $urandom_range(0, 1) ? coord_t'(CMAX) : coord_t'(-CMAX);
	endfunction

	// A coordinate a few millimetres away from c, kept inside the legal range.
	function automatic coord_t nudge(input coord_t c);
		int v;
		v = int'(c) + int'($urandom_range(0, 16)) - 8;
		if (v > CMAX || v < -CMAX)
			v = int'(c);
		return coord_t'(v);
	endfunction

	// Random beat. Half are plain full-range positions; the rest aim at the corners of the
	// behavior: extreme coordinates, near neighbours, and beacons on an axis of the sensor.
	function automatic beacon_t random_beacon();
		beacon_t b;
		int      kind;
		b.own_x    = rand_coord();
		b.own_y    = rand_coord();
		b.own_z    = rand_coord();
		b.target_x = rand_coord();
		b.target_y = rand_coord();
		b.target_z = rand_coord();
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				b.own_x    = rand_extreme();
				b.own_y    = rand_extreme();
				b.own_z    = rand_extreme();
				b.target_x = rand_extreme();
				b.target_y = rand_extreme();
				b.target_z = rand_extreme();
			end
			1: begin
				b.target_x = nudge(b.own_x);
				b.target_y = nudge(b.own_y);
				b.target_z = nudge(b.own_z);
			end
			2: begin
				b.target_z = b.own_z;
			end
			3: begin
				b.target_x = b.own_x;
			end
			4: begin
				b.target_x = b.own_x;
				b.target_z = b.own_z;
			end
			default: begin
			end
		endcase
		b.is_self = ($urandom_range(0, 9) == 0);
		return b;
	endfunction

	// Offers one beat after a random gap and holds it until the block takes it. The
	// expectation is queued at the accepting edge, so it always sees the mode in force.
	task automatic send_beacon(input beacon_t b);
		int gap;
		gap = pick_idle(send_idle_on);
		repeat (gap) begin
			@(negedge clk);
			beacon_bus.valid <= 1'b0;
		end
		@(negedge clk);
		beacon_bus.valid    <= 1'b1;
		beacon_bus.own_x    <= b.own_x;
		beacon_bus.own_y    <= b.own_y;
		beacon_bus.own_z    <= b.own_z;
		beacon_bus.target_x <= b.target_x;
		beacon_bus.target_y <= b.target_y;
		beacon_bus.target_z <= b.target_z;
		beacon_bus.is_self  <= b.is_self;
		do
			@(posedge clk);
		while (beacon_bus.ready !== 1'b1);
		if (!b.is_self)
			pending_fixes.push_back(predict_fix(b));
	endtask

	// Stops offering beats and waits until every owed fix is in, then long enough for
	// any is_self beat still in the pipeline to fall out as well.
	task automatic drain_pipeline();
		@(negedge clk);
		beacon_bus.valid <= 1'b0;
		while (pending_fixes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Mode changes only with the pipeline empty.
	task automatic write_mode(input logic m);
		drain_pipeline();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		conv_mode = m;
	endtask

	// Mode is left at its reset value here: cartesian differences at full scale in both
	// directions, zero difference, and a beat that must vanish.
	task automatic test_cartesian_extremes();
		send_beacon(make_beacon(-CMAX, -CMAX, -CMAX, CMAX, CMAX, CMAX, 1'b0));
		send_beacon(make_beacon(CMAX, CMAX, CMAX, -CMAX, -CMAX, -CMAX, 1'b0));
		send_beacon(make_beacon(0, 0, 0, 0, 0, 0, 1'b0));
		send_beacon(make_beacon(CMAX, -CMAX, CMAX, CMAX, -CMAX, CMAX, 1'b0));
		send_beacon(make_beacon(-CMAX, CMAX, -CMAX, CMAX, -CMAX, CMAX, 1'b1));
		send_beacon(make_beacon(CMAX, -CMAX, 0, -CMAX, CMAX, 1, 1'b0));
	endtask

	// Polar mode: every exact axis direction, both differences zero, the largest range,
	// bearings that crowd against plus and minus pi, and a suppressed beat.
	task automatic test_polar_cases();
		write_mode(MODE_POLAR);
		send_beacon(make_beacon(123, -45, 678, 123, 9000, 678, 1'b0));
		send_beacon(make_beacon(-10, 0, 50, 300, 0, 50, 1'b0));
		send_beacon(make_beacon(300, 7, 50, -10, 0, 50, 1'b0));
		send_beacon(make_beacon(77, 0, -5, 77, 0, 4000, 1'b0));
		send_beacon(make_beacon(77, 0, 4000, 77, 0, -5, 1'b0));
		send_beacon(make_beacon(-CMAX, -CMAX, -CMAX, CMAX, CMAX, CMAX, 1'b0));
		send_beacon(make_beacon(CMAX, 0, 0, -CMAX, 0, 1, 1'b0));
		send_beacon(make_beacon(CMAX, 0, 0, -CMAX, 0, -1, 1'b0));
		send_beacon(make_beacon(0, 0, CMAX, 1, 0, -CMAX, 1'b0));
		send_beacon(make_beacon(0, 0, 0, -3, 0, -4, 1'b0));
		send_beacon(make_beacon(CMAX, CMAX, CMAX, -CMAX, -CMAX, -CMAX, 1'b0));
		send_beacon(make_beacon(5, 5, 5, 9, 1, 2, 1'b1));
	endtask

	// The receiver refuses results for a long stretch while beats keep coming back to
	// back, so the pipeline fills and the beacon channel has to stall.
	task automatic test_backpressure();
		send_idle_on = 1'b0;
		hold_off_cycles = 250;
		repeat (80)
			send_beacon(random_beacon());
		send_idle_on = 1'b1;
	endtask

	// Random beats in phases that alternate the mode; one phase runs with no idling on
	// either side so the block also sees a full-rate stretch.
	task automatic test_random_phases();
		int counted;
		beacon_t b;
		for (int phase = 0; phase < 6; phase++) begin
			write_mode(phase[0] ? MODE_CART : MODE_POLAR);
			send_idle_on = (phase != 3);
			recv_idle_on = (phase != 3);
			counted = 0;
			while (counted < 100) begin
				b = random_beacon();
				send_beacon(b);
				if (!b.is_self)
					counted++;
			end
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	// Result side: ready changes at the falling edge, with random stalls and, on request,
	// one long hold-off that this process counts down itself.
	initial begin
		int stall_left;
		stall_left = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				result_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				stall_left = pick_idle(recv_idle_on);
			end
		end
	end

	// Every accepted result beat is matched against the oldest owed fix.
	always @(posedge clk) begin : result_check
		fix_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (pending_fixes.size() == 0) begin
				$error("result beat with no fix owed: %0d %0d %0d", result_bus.first_value,
					result_bus.second_value, result_bus.third_value);
				mismatches++;
			end else begin
				want = pending_fixes.pop_front();
				if (result_bus.first_value !== want.first_value) begin
					$error("first_value: expected %0d, got %0d", want.first_value,
						result_bus.first_value);
					mismatches++;
				end
				if (result_bus.second_value !== want.second_value) begin
					$error("second_value: expected %0d, got %0d", want.second_value,
						result_bus.second_value);
					mismatches++;
				end
				if (result_bus.third_value !== want.third_value) begin
					$error("third_value: expected %0d, got %0d", want.third_value,
						result_bus.third_value);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		beacon_bus.valid    = 1'b0;
		beacon_bus.own_x    = '0;
		beacon_bus.own_y    = '0;
		beacon_bus.own_z    = '0;
		beacon_bus.target_x = '0;
		beacon_bus.target_y = '0;
		beacon_bus.target_z = '0;
		beacon_bus.is_self  = 1'b0;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		test_cartesian_extremes();
		test_polar_cases();
		test_backpressure();
		test_random_phases();

		drain_pipeline();
		if (mismatches == 0) begin
			$display("tb_relative_position_polar_converter: clean");
		end else begin
			$display("tb_relative_position_polar_converter: errors");
		end
		$finish;
	end

endmodule
